@@ rtl/core/slbm_pkg.sv @@
`default_nettype none

package slbm_pkg;

    // Serial loader depth and widths fixed by the bus protocol
    localparam int LOAD_BITS  = 5;
    localparam int CNT_W      = 3;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int MAP_W      = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Control register value after reset: 32KB PRG, 4KB CHR bits as published
    localparam logic [LOAD_BITS-1:0] CONTROL_RESET = 5'h10;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_PRG   = 2'd1,
        REQ_CHR   = 2'd2,
        REQ_WRAM  = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        TGT_PRG     = 3'd0,
        TGT_CHR_ROM = 3'd1,
        TGT_CHR_RAM = 3'd2,
        TGT_WRAM    = 3'd3,
        TGT_NONE    = 3'd4
    } target_t;

    // Register chosen by address bits 14:13 on the loading write
    typedef enum logic [1:0] {
        SEL_CONTROL  = 2'd0,
        SEL_CHR_LOW  = 2'd1,
        SEL_CHR_HIGH = 2'd2,
        SEL_PRG      = 2'd3
    } reg_sel_t;

    // PRG banking modes from control bits 3:2
    typedef enum logic [1:0] {
        PRG_32K_A   = 2'd0,
        PRG_32K_B   = 2'd1,
        PRG_FIX_LOW = 2'd2,
        PRG_FIX_TOP = 2'd3
    } prg_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRG_BANK_COUNT = 2'd0,
        CFG_CHR_IS_RAM     = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [LOAD_BITS-1:0] control;
        logic [LOAD_BITS-1:0] chr_low;
        logic [LOAD_BITS-1:0] chr_high;
        logic [LOAD_BITS-1:0] prg;
    } bank_regs_t;

endpackage

`default_nettype wire

@@ rtl/core/serial_loaded_bank_mapper.sv @@
// A beat in the input register is translated straight into the result register,
// which drives the outputs; throughput is one beat per cycle while out_stall is low.
// in_stall rises only while both registers are full and out_stall is high.
// Reset (rst_n low, asynchronous) empties both stages, clears the serial loader,
// sets control to 0x10, bank registers to 0, prg_bank_count to 2, chr_is_ram to 0.
`default_nettype none

module serial_loaded_bank_mapper (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire  [1:0]                       req_type,
    input  wire  [slbm_pkg::ADDR_W-1:0]      address,
    input  wire  [slbm_pkg::DATA_W-1:0]      write_data,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [slbm_pkg::MAP_W-1:0]       mapped_address,
    output logic [2:0]                       target,
    output logic                             access_ok,
    output logic [1:0]                       mirroring,
    output logic                             control_changed,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [slbm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [slbm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import slbm_pkg::*;

    logic                  in_full_reg;
    req_type_t             req_reg;
    logic [ADDR_W-1:0]     address_reg;
    logic [DATA_W-1:0]     data_reg;

    logic                  out_full_reg;
    logic [MAP_W-1:0]      mapped_reg;
    target_t               target_reg;
    logic                  ok_reg;
    logic [1:0]            mirror_reg;
    logic                  changed_reg;

    logic [CFG_DATA_W-1:0] prg_bank_count_reg;
    logic                  chr_is_ram_reg;

    logic                  out_free;
    logic                  advance;
    bank_regs_t            regs;
    bank_regs_t            regs_next;
    logic                  ctl_load;
    logic [MAP_W-1:0]      mapped_c;
    target_t               target_c;
    logic                  ok_c;

    assign out_free  = !out_full_reg || !out_stall;
    assign advance   = in_full_reg && out_free;
    assign in_stall  = in_full_reg && !out_free;
    assign cfg_ready = 1'b1;

    // Capture the input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (!in_stall)
            in_full_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_reg     <= req_type_t'(req_type);
            address_reg <= address;
            data_reg    <= write_data;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_bank_count_reg <= CFG_DATA_W'(2);
            chr_is_ram_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PRG_BANK_COUNT: prg_bank_count_reg <= cfg_data;
                CFG_CHR_IS_RAM:     chr_is_ram_reg     <= cfg_data[0];
                default:            chr_is_ram_reg     <= chr_is_ram_reg;
            endcase
        end
    end

    slbm_loader u_loader (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (advance && (req_reg == REQ_WRITE)),
        .wr_address (address_reg),
        .wr_data    (data_reg),
        .regs       (regs),
        .regs_next  (regs_next),
        .ctl_load   (ctl_load)
    );

    slbm_translate u_translate (
        .req            (req_reg),
        .address        (address_reg),
        .regs           (regs),
        .prg_bank_count (prg_bank_count_reg),
        .chr_is_ram     (chr_is_ram_reg),
        .mapped         (mapped_c),
        .target         (target_c),
        .ok             (ok_c)
    );

    // Advance into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_full_reg <= 1'b0;
        else if (out_free)
            out_full_reg <= in_full_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mapped_reg  <= mapped_c;
            target_reg  <= target_c;
            ok_reg      <= ok_c;
            mirror_reg  <= regs_next.control[1:0];
            changed_reg <= ctl_load;
        end
    end

    assign out_valid       = out_full_reg;
    assign mapped_address  = mapped_reg;
    assign target          = target_reg;
    assign access_ok       = ok_reg;
    assign mirroring       = mirror_reg;
    assign control_changed = changed_reg;

    // Stall only with both stages full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_full_reg && out_full_reg))
        else $error("input stalled with a free stage");

    // A control load comes only from a register write
    a_changed_none: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && control_changed) |-> (target_reg == TGT_NONE))
        else $error("control change on a non-write result");

    // A refused access is a work RAM access with a zero offset
    a_refused_wram: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !access_ok) |-> ((target_reg == TGT_WRAM) && (mapped_reg == '0)))
        else $error("refused access outside work RAM");

    // Bank state moves only on an advancing write
    a_regs_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && (req_reg == REQ_WRITE)) |=> $stable(regs))
        else $error("bank registers changed without a write");

endmodule

`default_nettype wire

@@ rtl/core/slbm_loader.sv @@
`default_nettype none

module slbm_loader (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            wr_en,
    input  wire  [slbm_pkg::ADDR_W-1:0]    wr_address,
    input  wire  [slbm_pkg::DATA_W-1:0]    wr_data,
    output slbm_pkg::bank_regs_t           regs,
    output slbm_pkg::bank_regs_t           regs_next,
    output logic                           ctl_load
);
    import slbm_pkg::*;

    logic [LOAD_BITS-1:0] shift_reg;
    logic [LOAD_BITS-1:0] shift_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [LOAD_BITS-1:0] shifted;
    bank_regs_t           regs_reg;

    assign regs    = regs_reg;
    assign shifted = {wr_data[0], shift_reg[LOAD_BITS-1:1]};

    // Shift one bit per write, clear on bit 7, load register on last bit
    always_comb
    begin
        shift_next = shift_reg;
        count_next = count_reg;
        regs_next  = regs_reg;
        ctl_load   = 1'b0;
        if (wr_en && wr_address[ADDR_W-1])
        begin
            if (wr_data[DATA_W-1])
            begin
                shift_next = '0;
                count_next = '0;
            end
            else if (count_reg == CNT_W'(LOAD_BITS - 1))
            begin
                shift_next = '0;
                count_next = '0;
                unique case (reg_sel_t'(wr_address[14:13]))
                    SEL_CONTROL:
                    begin
                        regs_next.control = shifted;
                        ctl_load          = 1'b1;
                    end
                    SEL_CHR_LOW:  regs_next.chr_low  = shifted;
                    SEL_CHR_HIGH: regs_next.chr_high = shifted;
                    SEL_PRG:      regs_next.prg      = shifted;
                    default:      regs_next          = regs_reg;
                endcase
            end
            else
            begin
                shift_next = shifted;
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    // Hold loader and bank state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg         <= '0;
            count_reg         <= '0;
            regs_reg.control  <= CONTROL_RESET;
            regs_reg.chr_low  <= '0;
            regs_reg.chr_high <= '0;
            regs_reg.prg      <= '0;
        end
        else
        begin
            shift_reg <= shift_next;
            count_reg <= count_next;
            regs_reg  <= regs_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/slbm_translate.sv @@
`default_nettype none

module slbm_translate (
    input  slbm_pkg::req_type_t             req,
    input  wire  [slbm_pkg::ADDR_W-1:0]     address,
    input  slbm_pkg::bank_regs_t            regs,
    input  wire  [slbm_pkg::CFG_DATA_W-1:0] prg_bank_count,
    input  wire                             chr_is_ram,
    output logic [slbm_pkg::MAP_W-1:0]      mapped,
    output slbm_pkg::target_t               target,
    output logic                            ok
);
    import slbm_pkg::*;

    logic [3:0]   last_bank;
    logic [3:0]   bank16;
    logic [MAP_W-1:0] prg_addr;
    logic [MAP_W-1:0] chr_addr;
    logic [LOAD_BITS-1:0] chr_bank;

    // Clamp the bank count to 1..16 and take the last bank
    always_comb
    begin
        if (prg_bank_count == '0)
            last_bank = 4'd0;
        else if (prg_bank_count[4])
            last_bank = 4'hF;
        else
            last_bank = prg_bank_count[3:0] - 4'd1;
    end

    // PRG window: 32KB or 16KB banking
    always_comb
    begin
        bank16 = 4'd0;
        unique case (prg_mode_t'(regs.control[3:2]))
            PRG_FIX_LOW: bank16 = address[14] ? regs.prg[3:0] : 4'd0;
            PRG_FIX_TOP: bank16 = address[14] ? last_bank : regs.prg[3:0];
            default:     bank16 = 4'd0;
        endcase
        if (regs.control[3])
            prg_addr = {bank16, address[13:0]};
        else
            prg_addr = {regs.prg[3:1], address[14:0]};
    end

    // CHR window: one 8KB bank or two 4KB banks
    always_comb
    begin
        chr_bank = address[12] ? regs.chr_high : regs.chr_low;
        if (regs.control[4])
            chr_addr = {1'b0, chr_bank, address[11:0]};
        else
            chr_addr = {1'b0, regs.chr_low[4:1], address[12:0]};
    end

    // Select target and offset by request type
    always_comb
    begin
        mapped = '0;
        target = TGT_NONE;
        ok     = 1'b1;
        unique case (req)
            REQ_WRITE:
            begin
                target = TGT_NONE;
            end
            REQ_PRG:
            begin
                mapped = prg_addr;
                target = TGT_PRG;
            end
            REQ_CHR:
            begin
                if (chr_is_ram)
                begin
                    mapped = {5'd0, address[12:0]};
                    target = TGT_CHR_RAM;
                end
                else
                begin
                    mapped = chr_addr;
                    target = TGT_CHR_ROM;
                end
            end
            REQ_WRAM:
            begin
                target = TGT_WRAM;
                if (regs.prg[4])
                    ok = 1'b0;
                else
                    mapped = {5'd0, address[12:0]};
            end
            default:
            begin
                target = TGT_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire
